/* rtl/core/csvg_pkg.sv */
// Shared types and constants of the cube-to-sphere vertex generator.
// No dependencies; used by the top level cube_to_sphere_vertex_generator in rtl/core.
package csvg_pkg;

  // Register file
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS  = 2'd0,
    CFG_PATCHES = 2'd1,
    CFG_VERTS   = 2'd2
  } cfg_idx_e;

  localparam int unsigned RadiusW = 24;
  localparam int unsigned PatchCntW = 9;
  localparam int unsigned VertCntW = 7;

  localparam logic [RadiusW-1:0] RadiusRst = 24'd6371000;
  localparam logic [PatchCntW-1:0] PatchCntRst = 9'd1;
  localparam logic [VertCntW-1:0] VertCntRst = 7'd33;

  localparam logic [PatchCntW-1:0] PatchCntMin = 9'd1;
  localparam logic [PatchCntW-1:0] PatchCntMax = 9'd256;
  localparam logic [VertCntW-1:0] VertCntMin = 7'd2;
  localparam logic [VertCntW-1:0] VertCntMax = 7'd65;

  // Input word fields
  localparam int unsigned FaceW = 3;
  localparam int unsigned PatchW = 8;
  localparam int unsigned VertW = 7;

  typedef enum logic [FaceW-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  // Output word fields
  localparam int unsigned PosW = 25;
  localparam int unsigned DirW = 18;

  // Face coordinate arithmetic: grid span fits 15 bits, numerator magnitude 16
  localparam int unsigned SpanW = 15;
  localparam int unsigned NumMagW = 16;
  localparam int unsigned LinW = 16;
  localparam int unsigned NumW = 18;

endpackage

/* rtl/core/csvg_div.sv */
// Pipelined restoring divider: L lanes share one divisor, one quotient bit per stage.
// Gives round(num * 2^FRAC / den), ties away from zero, saturated to one. No package use.
module csvg_div #(
  parameter int unsigned L    = 2,
  parameter int unsigned NW   = 16,
  parameter int unsigned DW   = 15,
  parameter int unsigned FRAC = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [NW-1:0]          num_i [L],
  input  logic                   neg_i [L],
  input  logic [DW-1:0]          den_i,
  output logic                   valid_o,
  output logic signed [FRAC+1:0] quo_o [L]
);

  logic            valid_q [FRAC+1];
  logic [DW-1:0]   den_q   [FRAC+1];
  logic [DW-1:0]   rem_q   [FRAC+1][L];
  logic [FRAC-1:0] quo_q   [FRAC+1][L];
  logic            sat_q   [FRAC+1][L];
  logic            neg_q   [FRAC+1][L];

  logic                   valid_out_q;
  logic signed [FRAC+1:0] quo_out_q [L];

  // Entry stage: saturate when the numerator reaches the divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
    end
  end

  for (genvar l = 0; l < L; l++) begin : g_entry
    logic sat;
    assign sat = (num_i[l] >= NW'(den_i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sat_q[0][l] <= sat;
        neg_q[0][l] <= neg_i[l];
        rem_q[0][l] <= sat ? '0 : DW'(num_i[l]);
        quo_q[0][l] <= '0;
      end
    end
  end

  // Fraction stages: shift in one quotient bit each
  for (genvar k = 1; k <= FRAC; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_q[k-1];
      end
    end

    for (genvar l = 0; l < L; l++) begin : g_lane
      logic [DW:0] rem2;
      logic        take;
      assign rem2 = {rem_q[k-1][l], 1'b0};
      assign take = (rem2 >= {1'b0, den_q[k-1]});
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= take ? DW'(rem2 - {1'b0, den_q[k-1]}) : rem2[DW-1:0];
          quo_q[k][l] <= (quo_q[k-1][l] << 1) | FRAC'(take);
          sat_q[k][l] <= sat_q[k-1][l];
          neg_q[k][l] <= neg_q[k-1][l];
        end
      end
    end
  end

  // Round on the final remainder and apply the sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_out_q <= 1'b0;
    end else if (en_i) begin
      valid_out_q <= valid_q[FRAC];
    end
  end

  for (genvar l = 0; l < L; l++) begin : g_round
    logic            up;
    logic [FRAC:0]   mag;
    assign up  = ({rem_q[FRAC][l], 1'b0} >= {1'b0, den_q[FRAC]});
    assign mag = sat_q[FRAC][l] ? ((FRAC+1)'(1) << FRAC)
                                : ({1'b0, quo_q[FRAC][l]} + (FRAC+1)'(up));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_out_q[l] <= neg_q[FRAC][l] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
    end
    assign quo_o[l] = quo_out_q[l];
  end

  assign valid_o = valid_out_q;

endmodule

/* rtl/core/csvg_isqrt.sv */
// Pipelined integer square root, one root bit per stage, with a side word carried along.
// Input is known to lie in [2^(2*FRAC), 3*2^(2*FRAC)]. No package use.
module csvg_isqrt #(
  parameter int unsigned FRAC = 16,
  parameter int unsigned SW   = 54
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2*FRAC+1:0]     sq_i,
  input  logic [SW-1:0]         side_i,
  output logic                  valid_o,
  output logic [FRAC:0]         root_o,
  output logic [SW-1:0]         side_o
);

  localparam int unsigned SqW = 2*FRAC + 2;
  localparam int unsigned TW  = 2*FRAC + 3;
  localparam int unsigned RW  = FRAC + 1;

  logic          valid_q [RW];
  logic [SqW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q  [RW];
  logic [SW-1:0] side_q  [RW];

  // Stage k settles root bit FRAC-k
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int unsigned B = FRAC - k;
    logic           valid_in;
    logic [SqW-1:0] rem_in;
    logic [RW-1:0]  root_in;
    logic [SW-1:0]  side_in;
    logic [TW-1:0]  trial;
    logic           take;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = sq_i;
      assign root_in  = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
    assign take  = ({1'b0, rem_in} >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? SqW'({1'b0, rem_in} - trial) : rem_in;
        root_q[k] <= take ? (root_in | (RW'(1) << B)) : root_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

/* rtl/core/cube_to_sphere_vertex_generator.sv */
// Top level of the cube-to-sphere vertex generator: registers, grid front end,
// cube mapping, squares and scaling; uses csvg_pkg, csvg_div and csvg_isqrt.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i, in_ready_o, face..vert_row    | sink
//  out      | out_valid_o, out_ready_i, pos_*, dir_*    | source
//  cfg      | cfg_valid_i, cfg_ready_o, index, data     | sink
//
// One word per cycle is accepted while the output is not stalled; the pipeline is the two bit-serial
// dividers (FRAC_BITS+2 stages each), the square root (FRAC_BITS+1) and six single
// stages (front end, map, square, sum, scale, output).
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stalled output word freezes the whole pipeline; nothing is dropped or repeated.
// Configuration writes are always taken (cfg_ready_o is tied high).
module cube_to_sphere_vertex_generator #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned RADIUS_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [csvg_pkg::FaceW-1:0]          face_i,
  input  logic [csvg_pkg::PatchW-1:0]         patch_col_i,
  input  logic [csvg_pkg::PatchW-1:0]         patch_row_i,
  input  logic [csvg_pkg::VertW-1:0]          vert_col_i,
  input  logic [csvg_pkg::VertW-1:0]          vert_row_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [csvg_pkg::PosW-1:0]    pos_x_o,
  output logic signed [csvg_pkg::PosW-1:0]    pos_y_o,
  output logic signed [csvg_pkg::PosW-1:0]    pos_z_o,
  output logic signed [csvg_pkg::DirW-1:0]    dir_x_o,
  output logic signed [csvg_pkg::DirW-1:0]    dir_y_o,
  output logic signed [csvg_pkg::DirW-1:0]    dir_z_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [csvg_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [csvg_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned CW     = F + 2;
  localparam int unsigned SqW    = 2*F + 2;
  localparam int unsigned DivLat = F + 2;
  localparam int unsigned PW     = F + 1 + RADIUS_BITS;
  localparam int unsigned RndW   = RADIUS_BITS + 1;
  localparam int unsigned PExtW  = (RndW > csvg_pkg::PosW) ? RndW : csvg_pkg::PosW;
  localparam int unsigned DExtW  = (CW > csvg_pkg::DirW) ? CW : csvg_pkg::DirW;

  localparam logic signed [CW-1:0] One = CW'(1) << F;

  logic adv;

  // Configuration registers
  logic [csvg_pkg::RadiusW-1:0]   radius_q;
  logic [csvg_pkg::PatchCntW-1:0] patches_q;
  logic [csvg_pkg::VertCntW-1:0]  verts_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= csvg_pkg::RadiusRst;
      patches_q <= csvg_pkg::PatchCntRst;
      verts_q   <= csvg_pkg::VertCntRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        csvg_pkg::CFG_RADIUS:  radius_q  <= cfg_data_i;
        csvg_pkg::CFG_PATCHES: patches_q <= cfg_data_i[csvg_pkg::PatchCntW-1:0];
        csvg_pkg::CFG_VERTS:   verts_q   <= cfg_data_i[csvg_pkg::VertCntW-1:0];
        default: ;
      endcase
    end
  end

  // Radius as used by the scaler
  logic [RADIUS_BITS-1:0] rad;
  if (RADIUS_BITS >= csvg_pkg::RadiusW) begin : g_rad_wide
    assign rad = RADIUS_BITS'(radius_q);
  end else begin : g_rad_narrow
    assign rad = radius_q[RADIUS_BITS-1:0];
  end

  // Advance everything unless the output word is held
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Front end: clamp the counts and form the signed grid numerators
  logic [csvg_pkg::PatchCntW-1:0] p_cl;
  logic [csvg_pkg::VertCntW-1:0]  v_cl;
  logic [csvg_pkg::VertCntW-1:0]  vm1;
  logic [csvg_pkg::SpanW-1:0]     span;
  logic [csvg_pkg::LinW-1:0]      lin_u, lin_v;
  logic signed [csvg_pkg::NumW-1:0] n_u, n_v;

  always_comb begin
    p_cl = patches_q;
    if (patches_q < csvg_pkg::PatchCntMin) p_cl = csvg_pkg::PatchCntMin;
    if (patches_q > csvg_pkg::PatchCntMax) p_cl = csvg_pkg::PatchCntMax;
    v_cl = verts_q;
    if (verts_q < csvg_pkg::VertCntMin) v_cl = csvg_pkg::VertCntMin;
    if (verts_q > csvg_pkg::VertCntMax) v_cl = csvg_pkg::VertCntMax;
    vm1   = v_cl - csvg_pkg::VertCntW'(1);
    span  = csvg_pkg::SpanW'(csvg_pkg::LinW'(p_cl) * csvg_pkg::LinW'(vm1));
    lin_u = csvg_pkg::LinW'(patch_col_i) * csvg_pkg::LinW'(vm1)
          + csvg_pkg::LinW'(vert_col_i);
    lin_v = csvg_pkg::LinW'(patch_row_i) * csvg_pkg::LinW'(vm1)
          + csvg_pkg::LinW'(vert_row_i);
    n_u   = $signed({1'b0, lin_u, 1'b0}) - $signed({3'b0, span});
    n_v   = $signed({1'b0, lin_v, 1'b0}) - $signed({3'b0, span});
  end

  logic                          v_front_q;
  logic [csvg_pkg::NumMagW-1:0]  mag_front_q [2];
  logic                          neg_front_q [2];
  logic [csvg_pkg::SpanW-1:0]    span_front_q;
  logic [csvg_pkg::FaceW-1:0]    face_front_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_front_q <= 1'b0;
    end else if (adv) begin
      v_front_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_front_q[0] <= n_u[csvg_pkg::NumW-1] ? csvg_pkg::NumMagW'(-n_u)
                                              : n_u[csvg_pkg::NumMagW-1:0];
      mag_front_q[1] <= n_v[csvg_pkg::NumW-1] ? csvg_pkg::NumMagW'(-n_v)
                                              : n_v[csvg_pkg::NumMagW-1:0];
      neg_front_q[0] <= n_u[csvg_pkg::NumW-1];
      neg_front_q[1] <= n_v[csvg_pkg::NumW-1];
      span_front_q   <= span;
      face_front_q   <= face_i;
    end
  end

  // Face coordinates tu, tv
  logic                 v_coord;
  logic signed [CW-1:0] t_coord [2];

  csvg_div #(
    .L    (2),
    .NW   (csvg_pkg::NumMagW),
    .DW   (csvg_pkg::SpanW),
    .FRAC (F)
  ) u_coord_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_front_q),
    .num_i   (mag_front_q),
    .neg_i   (neg_front_q),
    .den_i   (span_front_q),
    .valid_o (v_coord),
    .quo_o   (t_coord)
  );

  // Delay the face code alongside the divider
  logic [csvg_pkg::FaceW-1:0] face_dly_q [DivLat];

  for (genvar k = 0; k < DivLat; k++) begin : g_face_dly
    always_ff @(posedge clk_i) begin
      if (adv) begin
        face_dly_q[k] <= (k == 0) ? face_front_q : face_dly_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Place the coordinates on the cube
  logic signed [CW-1:0] c_map [3];

  always_comb begin
    unique case (face_dly_q[DivLat-1])
      csvg_pkg::FACE_PX: begin
        c_map[0] = One;         c_map[1] = t_coord[1];  c_map[2] = t_coord[0];
      end
      csvg_pkg::FACE_NX: begin
        c_map[0] = -One;        c_map[1] = t_coord[1];  c_map[2] = -t_coord[0];
      end
      csvg_pkg::FACE_PY: begin
        c_map[0] = t_coord[0];  c_map[1] = One;         c_map[2] = t_coord[1];
      end
      csvg_pkg::FACE_NY: begin
        c_map[0] = t_coord[0];  c_map[1] = -One;        c_map[2] = -t_coord[1];
      end
      csvg_pkg::FACE_PZ: begin
        c_map[0] = -t_coord[0]; c_map[1] = t_coord[1];  c_map[2] = One;
      end
      csvg_pkg::FACE_NZ: begin
        c_map[0] = t_coord[0];  c_map[1] = t_coord[1];  c_map[2] = -One;
      end
      default: begin
        c_map[0] = One;         c_map[1] = '0;          c_map[2] = '0;
      end
    endcase
  end

  logic                 v_map_q, v_sq_q, v_sum_q;
  logic signed [CW-1:0] c_map_q [3];
  logic signed [CW-1:0] c_sq_q  [3];
  logic signed [CW-1:0] c_sum_q [3];
  logic [SqW-1:0]       sq_q    [3];
  logic [SqW-1:0]       sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_map_q <= 1'b0;
      v_sq_q  <= 1'b0;
      v_sum_q <= 1'b0;
    end else if (adv) begin
      v_map_q <= v_coord;
      v_sq_q  <= v_map_q;
      v_sum_q <= v_sq_q;
    end
  end

  // Square each component, then sum
  for (genvar i = 0; i < 3; i++) begin : g_sq
    logic signed [2*CW-1:0] prod;
    assign prod = c_map_q[i] * c_map_q[i];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        c_map_q[i] <= c_map[i];
        sq_q[i]    <= prod[SqW-1:0];
        c_sq_q[i]  <= c_map_q[i];
        c_sum_q[i] <= c_sq_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // Length of the cube point
  logic            v_root;
  logic [F:0]      root;
  logic [3*CW-1:0] c_root;

  csvg_isqrt #(
    .FRAC (F),
    .SW   (3*CW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_sum_q),
    .sq_i    (sum_q),
    .side_i  ({c_sum_q[0], c_sum_q[1], c_sum_q[2]}),
    .valid_o (v_root),
    .root_o  (root),
    .side_o  (c_root)
  );

  // Normalize each component
  logic signed [CW-1:0] c_un   [3];
  logic [F:0]           c_mag  [3];
  logic                 c_neg  [3];
  logic                 v_dir;
  logic signed [CW-1:0] dir    [3];

  assign c_un[0] = $signed(c_root[3*CW-1:2*CW]);
  assign c_un[1] = $signed(c_root[2*CW-1:CW]);
  assign c_un[2] = $signed(c_root[CW-1:0]);

  for (genvar i = 0; i < 3; i++) begin : g_cmag
    assign c_neg[i] = c_un[i][CW-1];
    assign c_mag[i] = c_neg[i] ? (F+1)'(-c_un[i]) : c_un[i][F:0];
  end

  csvg_div #(
    .L    (3),
    .NW   (F + 1),
    .DW   (F + 1),
    .FRAC (F)
  ) u_dir_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_root),
    .num_i   (c_mag),
    .neg_i   (c_neg),
    .den_i   (root),
    .valid_o (v_dir),
    .quo_o   (dir)
  );

  // Scale by the radius, then round and drive the output word
  logic                 v_p_q;
  logic [PW-1:0]        pmag_q [3];
  logic                 pneg_q [3];
  logic signed [CW-1:0] dir_p_q [3];

  logic signed [csvg_pkg::PosW-1:0] pos_q [3];
  logic signed [csvg_pkg::DirW-1:0] dir_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_p_q       <= v_dir;
      out_valid_q <= v_p_q;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_pos
    logic [F:0]                   dmag;
    logic [PW-1:0]                rsum;
    logic [RndW-1:0]              rnd;
    logic [PExtW-1:0]             rext;
    logic [csvg_pkg::PosW-1:0]    pmag25;
    logic signed [DExtW-1:0]      dext;

    assign dmag   = dir[i][CW-1] ? (F+1)'(-dir[i]) : dir[i][F:0];
    assign rsum   = pmag_q[i] + (PW'(1) << (F - 1));
    assign rnd    = rsum[PW-1:F];
    assign rext   = PExtW'(rnd);
    assign pmag25 = rext[csvg_pkg::PosW-1:0];
    assign dext   = DExtW'(dir_p_q[i]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pmag_q[i]  <= PW'(dmag) * PW'(rad);
        pneg_q[i]  <= dir[i][CW-1];
        dir_p_q[i] <= dir[i];
        pos_q[i]   <= pneg_q[i] ? -$signed(pmag25) : $signed(pmag25);
        dir_q[i]   <= dext[csvg_pkg::DirW-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_q[0];
  assign pos_y_o     = pos_q[1];
  assign pos_z_o     = pos_q[2];
  assign dir_x_o     = dir_q[0];
  assign dir_y_o     = dir_q[1];
  assign dir_z_o     = dir_q[2];

endmodule
